### hw/rtl/ct2d_pkg.sv
// Shared constants and types for the 2D collision test block.
package ct2d_pkg;

   localparam int COORD_BITS_DEFAULT = 24;

   typedef enum logic {
      SHAPE_CIRCLE = 1'b0,
      SHAPE_RECT   = 1'b1
   } shape_type;

   // Which of the three tests applies to a pair of shapes.
   typedef enum logic [1:0] {
      PAIR_CIRC_CIRC = 2'd0,
      PAIR_CIRC_RECT = 2'd1,
      PAIR_RECT_RECT = 2'd2
   } pair_type;

endpackage

### hw/rtl/collision_test_2d.sv
// Top level of the 2D circle and rectangle overlap test.
//
// Each beat on the req_ channel carries two shapes, each a circle or an
// axis-aligned rectangle given by its center; the rsp_ channel returns one
// overlap flag per beat, in order. The block accepts one pair every cycle
// while req_stall is low and presents the flag on rsp_ through four register
// stages: stage one forms the doubled center distances, stage two clamps
// them against the rectangle and picks the operands, stage three squares
// them in three COORD_BITS+1 bit multipliers, and stage four adds and
// compares into the output register. A stall on the rsp_ side fills empty
// stages first and only then stalls the req_ side.
// Touching circles and touching rectangles do not overlap; a circle touching
// a rectangle does.
module collision_test_2d #(
   parameter int COORD_BITS = ct2d_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_first_shape,
   input  logic signed [COORD_BITS-1:0] req_first_center_x,
   input  logic signed [COORD_BITS-1:0] req_first_center_y,
   input  logic [COORD_BITS-2:0]        req_first_extent_a,
   input  logic [COORD_BITS-2:0]        req_first_extent_b,
   input  logic                         req_second_shape,
   input  logic signed [COORD_BITS-1:0] req_second_center_x,
   input  logic signed [COORD_BITS-1:0] req_second_center_y,
   input  logic [COORD_BITS-2:0]        req_second_extent_a,
   input  logic [COORD_BITS-2:0]        req_second_extent_b,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_overlap
);

   localparam int W  = COORD_BITS;
   localparam int MW = W + 1;     // magnitude of a doubled distance
   localparam int DW = W + 2;     // signed difference of doubled centers
   localparam int SW = 2 * MW;    // square of a magnitude

   // Stage control.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic load1, load2, load3, load4;

   assign load4 = !v4_ff || !rsp_stall;
   assign load3 = !v3_ff || load4;
   assign load2 = !v2_ff || load3;
   assign load1 = !v1_ff || load2;

   assign v1_in = load1 ? req_valid : v1_ff;
   assign v2_in = load2 ? v1_ff     : v2_ff;
   assign v3_in = load3 ? v2_ff     : v3_ff;
   assign v4_in = load4 ? v3_ff     : v4_ff;

   assign req_stall = !load1;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Stage one: doubled center distances, extent sums and test selection.
   logic signed [DW-1:0]  diff_x, diff_y;
   logic [MW-1:0]         adx_in, ady_in, adx_ff, ady_ff;
   logic [W-1:0]          sum_a_in, sum_b_in, sum_a_ff, sum_b_ff;
   logic [W-2:0]          circ_r_in, rect_a_in, rect_b_in;
   logic [W-2:0]          circ_r_ff, rect_a_ff, rect_b_ff;
   ct2d_pkg::pair_type    pair1_in, pair1_ff;
   logic [DW-1:0]         neg_x, neg_y;

   assign diff_x = DW'($signed({req_first_center_x, 1'b0}))
                 - DW'($signed({req_second_center_x, 1'b0}));
   assign diff_y = DW'($signed({req_first_center_y, 1'b0}))
                 - DW'($signed({req_second_center_y, 1'b0}));
   assign neg_x  = ~diff_x + DW'(1);
   assign neg_y  = ~diff_y + DW'(1);

   always_comb begin
      adx_in   = diff_x[DW-1] ? neg_x[MW-1:0] : diff_x[MW-1:0];
      ady_in   = diff_y[DW-1] ? neg_y[MW-1:0] : diff_y[MW-1:0];
      sum_a_in = W'(req_first_extent_a) + W'(req_second_extent_a);
      sum_b_in = W'(req_first_extent_b) + W'(req_second_extent_b);
      // The circle-rectangle test is symmetric in the order of the shapes.
      if (req_first_shape == ct2d_pkg::SHAPE_CIRCLE) begin
         circ_r_in = req_first_extent_a;
         rect_a_in = req_second_extent_a;
         rect_b_in = req_second_extent_b;
      end else begin
         circ_r_in = req_second_extent_a;
         rect_a_in = req_first_extent_a;
         rect_b_in = req_first_extent_b;
      end
      if (req_first_shape == ct2d_pkg::SHAPE_CIRCLE &&
          req_second_shape == ct2d_pkg::SHAPE_CIRCLE) begin
         pair1_in = ct2d_pkg::PAIR_CIRC_CIRC;
      end else if (req_first_shape == ct2d_pkg::SHAPE_RECT &&
                   req_second_shape == ct2d_pkg::SHAPE_RECT) begin
         pair1_in = ct2d_pkg::PAIR_RECT_RECT;
      end else begin
         pair1_in = ct2d_pkg::PAIR_CIRC_RECT;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         adx_ff    <= adx_in;
         ady_ff    <= ady_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         circ_r_ff <= circ_r_in;
         rect_a_ff <= rect_a_in;
         rect_b_ff <= rect_b_in;
         pair1_ff  <= pair1_in;
      end
   end

   // Stage two: clamp against the rectangle, choose multiplier operands.
   // Clamping the circle center into the box leaves a per-axis distance of
   // the center distance less the half size, or zero when inside.
   logic [MW-1:0]       ex, ey;
   logic [MW-1:0]       op_x_in, op_y_in, op_r_in;
   logic [MW-1:0]       op_x_ff, op_y_ff, op_r_ff;
   logic                rect_hit_in, rect_hit_ff;
   ct2d_pkg::pair_type  pair2_ff;

   always_comb begin
      ex = (adx_ff > MW'(rect_a_ff)) ? adx_ff - MW'(rect_a_ff) : '0;
      ey = (ady_ff > MW'(rect_b_ff)) ? ady_ff - MW'(rect_b_ff) : '0;
      rect_hit_in = (adx_ff < MW'(sum_a_ff)) && (ady_ff < MW'(sum_b_ff));
      case (pair1_ff)
         ct2d_pkg::PAIR_CIRC_CIRC: begin
            op_x_in = adx_ff;
            op_y_in = ady_ff;
            op_r_in = {sum_a_ff, 1'b0};
         end
         ct2d_pkg::PAIR_CIRC_RECT: begin
            op_x_in = ex;
            op_y_in = ey;
            op_r_in = {1'b0, circ_r_ff, 1'b0};
         end
         default: begin
            op_x_in = adx_ff;
            op_y_in = ady_ff;
            op_r_in = {sum_a_ff, 1'b0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         op_x_ff     <= op_x_in;
         op_y_ff     <= op_y_in;
         op_r_ff     <= op_r_in;
         rect_hit_ff <= rect_hit_in;
         pair2_ff    <= pair1_ff;
      end
   end

   // Stage three: squares.
   logic [SW-1:0]       sq_x, sq_y, sq_r;
   logic                rect_hit3_ff;
   ct2d_pkg::pair_type  pair3_ff;

   ct2d_square #(.WIDTH(MW)) u_square_x (
      .clock   (clock),
      .enable  (load3),
      .operand (op_x_ff),
      .square  (sq_x)
   );

   ct2d_square #(.WIDTH(MW)) u_square_y (
      .clock   (clock),
      .enable  (load3),
      .operand (op_y_ff),
      .square  (sq_y)
   );

   ct2d_square #(.WIDTH(MW)) u_square_r (
      .clock   (clock),
      .enable  (load3),
      .operand (op_r_ff),
      .square  (sq_r)
   );

   always_ff @(posedge clock) begin
      if (load3) begin
         rect_hit3_ff <= rect_hit_ff;
         pair3_ff     <= pair2_ff;
      end
   end

   // Stage four: sum of squares against the squared radius, or the rectangle hit flag for two rectangles.
   logic [SW:0] dist_sq, rad_sq;
   logic        overlap_in, overlap_ff;

   assign dist_sq = (SW + 1)'(sq_x) + (SW + 1)'(sq_y);
   assign rad_sq  = {1'b0, sq_r};

   always_comb begin
      case (pair3_ff)
         ct2d_pkg::PAIR_CIRC_CIRC: overlap_in = dist_sq < rad_sq;
         ct2d_pkg::PAIR_CIRC_RECT: overlap_in = rad_sq >= dist_sq;
         default:                  overlap_in = rect_hit3_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         overlap_ff <= overlap_in;
      end
   end

   assign rsp_overlap = overlap_ff;

endmodule

### hw/rtl/ct2d_square.sv
// Registered unsigned squarer used by the squaring stage (stage three).
module ct2d_square #(
   parameter int WIDTH = ct2d_pkg::COORD_BITS_DEFAULT + 1
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [WIDTH-1:0]     operand,
   output logic [2*WIDTH-1:0]   square
);

   logic [2*WIDTH-1:0] wide_operand;
   logic [2*WIDTH-1:0] square_in;
   logic [2*WIDTH-1:0] square_ff;

   assign wide_operand = {{WIDTH{1'b0}}, operand};
   assign square_in    = wide_operand * wide_operand;
   assign square       = square_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         square_ff <= square_in;
      end
   end

endmodule
